// File: hw/rtl/wfg_pkg.sv
// ----------------------------------------------------------------------------
// wfg_pkg
// Shared types and constants for the wait-for graph deadlock detector.
// ----------------------------------------------------------------------------
package wfg_pkg;

	// number of transaction slots tracked by the graph
	localparam int NUM_TXN = 32;
	localparam int SLOT_W  = $clog2(NUM_TXN);
	localparam int DEPTH_W = $clog2(NUM_TXN + 1);

	// fixed widths of the item fields
	localparam int CMD_W   = 2;
	localparam int FIELD_W = 5;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DETECT = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [FIELD_W-1:0] waiter;
		logic [FIELD_W-1:0] holder;
	} in_item_t;

	typedef struct packed {
		logic               found;
		logic [FIELD_W-1:0] victim;
	} out_item_t;

	// edge update toward the matrix
	typedef struct packed {
		logic              en;
		logic              set;
		logic [SLOT_W-1:0] row;
		logic [SLOT_W-1:0] col;
	} wfg_wr_t;

	// outcome of one search
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] victim;
	} wfg_res_t;

endpackage

// File: hw/rtl/wfg_edge_store.sv
// ----------------------------------------------------------------------------
// wfg_edge_store
// Wait-for edge matrix: one row per waiter, one bit per holder.
// ----------------------------------------------------------------------------
module wfg_edge_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wfg_pkg::wfg_wr_t            wr,
	input  logic [wfg_pkg::SLOT_W-1:0]  rd_addr,
	output logic [wfg_pkg::NUM_TXN-1:0] rd_row
);
	import wfg_pkg::*;

	logic [NUM_TXN-1:0] mtx_q [NUM_TXN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TXN; i++) begin
				mtx_q[i] <= '0;
			end
		end else if (wr.en) begin
			mtx_q[wr.row][wr.col] <= wr.set;
		end
	end

	assign rd_row = mtx_q[rd_addr];

endmodule

// File: hw/rtl/wfg_ffs.sv
// ----------------------------------------------------------------------------
// wfg_ffs
// Lowest-set-bit finder shared by root selection and neighbor scan.
// ----------------------------------------------------------------------------
module wfg_ffs (
	input  logic [wfg_pkg::NUM_TXN-1:0] vec,
	output logic                        hit,
	output logic [wfg_pkg::SLOT_W-1:0]  idx
);
	import wfg_pkg::*;

	always_comb begin
		idx = '0;
		for (int i = NUM_TXN - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx = SLOT_W'(i);
			end
		end
		hit = |vec;
	end

endmodule

// File: hw/rtl/wfg_search.sv
// ----------------------------------------------------------------------------
// wfg_search
// Depth-first cycle search sequencer with path stack and vertex marks.
// ----------------------------------------------------------------------------
module wfg_search (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic [wfg_pkg::SLOT_W-1:0]  row_addr,
	input  logic [wfg_pkg::NUM_TXN-1:0] row,
	output logic                        busy,
	output logic                        res_valid,
	output wfg_pkg::wfg_res_t           res
);
	import wfg_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_ROOT = 4'b0010,
		S_SCAN = 4'b0100,
		S_WALK = 4'b1000
	} state_t;

	state_t              state_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic [SLOT_W-1:0]   path_q [NUM_TXN];
	logic [NUM_TXN-1:0]  onpath_q;
	logic [NUM_TXN-1:0]  fin_q;
	logic [SLOT_W-1:0]   tgt_q;
	logic [SLOT_W-1:0]   best_q;
	logic                res_valid_q;
	wfg_res_t            res_q;

	logic [DEPTH_W-1:0]  depth_m1;
	logic [SLOT_W-1:0]   top;
	logic [NUM_TXN-1:0]  ffs_vec;
	logic                ffs_hit;
	logic [SLOT_W-1:0]   ffs_idx;
	logic [SLOT_W-1:0]   best_nx;

	// top of the path stack; walk-back reuses the same read port
	assign depth_m1 = depth_q - DEPTH_W'(1);
	assign top      = path_q[depth_m1[SLOT_W-1:0]];
	assign row_addr = top;
	assign best_nx  = (top > best_q) ? top : best_q;

	// roots: first unfinished slot; scan: first unfinished neighbor
	always_comb begin
		case (state_q)
			S_ROOT:  ffs_vec = ~fin_q;
			default: ffs_vec = row & ~fin_q;
		endcase
	end

	wfg_ffs u_ffs (
		.vec (ffs_vec),
		.hit (ffs_hit),
		.idx (ffs_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			onpath_q    <= '0;
			fin_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						depth_q  <= '0;
						onpath_q <= '0;
						fin_q    <= '0;
						state_q  <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (ffs_hit) begin
						onpath_q[ffs_idx] <= 1'b1;
						depth_q           <= DEPTH_W'(1);
						state_q           <= S_SCAN;
					end else begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (ffs_hit && onpath_q[ffs_idx]) begin
						state_q <= S_WALK;
					end else if (ffs_hit) begin
						onpath_q[ffs_idx] <= 1'b1;
						depth_q           <= depth_q + DEPTH_W'(1);
					end else begin
						// vertex finished, pop it
						fin_q[top]    <= 1'b1;
						onpath_q[top] <= 1'b0;
						depth_q       <= depth_m1;
						if (depth_q == DEPTH_W'(1)) begin
							state_q <= S_ROOT;
						end
					end
				end
				S_WALK: begin
					if (top == tgt_q || depth_q == DEPTH_W'(1)) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						depth_q <= depth_m1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: stack entries, cycle target, running maximum, result
	always_ff @(posedge clk) begin
		case (state_q)
			S_ROOT: begin
				path_q[0] <= ffs_idx;
				res_q     <= '0;
			end
			S_SCAN: begin
				if (ffs_hit && onpath_q[ffs_idx]) begin
					tgt_q  <= ffs_idx;
					best_q <= '0;
				end else if (ffs_hit) begin
					path_q[depth_q[SLOT_W-1:0]] <= ffs_idx;
				end
			end
			S_WALK: begin
				best_q       <= best_nx;
				res_q.found  <= 1'b1;
				res_q.victim <= best_nx;
			end
			default: begin
				best_q <= best_q;
			end
		endcase
	end

	assign busy      = (state_q != S_IDLE) || res_valid_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// a slot is never both on the path and finished
	a_marks_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		(onpath_q & fin_q) == '0)
		else $error("slot marked both on path and finished");

	// the stack depth tracks the number of slots on the path
	a_depth_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_ROOT) |-> $countones(onpath_q) == depth_q)
		else $error("stack depth out of step with path marks");

	// a root is picked only with an empty path
	a_root_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROOT |-> depth_q == '0)
		else $error("root selection with nonempty path");

	// no cycle reports no victim
	a_nofind_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.found) |-> res_q.victim == '0)
		else $error("victim reported without a cycle");

endmodule

// File: hw/rtl/wait_for_graph_deadlock_detector.sv
// ----------------------------------------------------------------------------
// wait_for_graph_deadlock_detector
// Wait-for graph over transaction slots with depth-first deadlock search.
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_ready/in_data carries one command item: add edge, remove edge
//   or detect cycle; out_valid/out_ready/out_data returns exactly one result
//   item per command (found flag and victim slot)
//   add and remove update one bit of the edge matrix and post their result
//   straight into the output register as the item is taken
//   detect walks the graph with one shared lowest-set-bit finder: root picks,
//   descents to unfinished neighbours and pops of finished slots, plus a walk
//   back over the slots on the cycle once one is found; the search result is
//   registered and then loads the output register
//   the block takes one command at a time; in_ready is low while a search runs
//   a new command is taken while the output register is empty or being read,
//   so a detect is not taken before the search ahead of it has posted its result
//   reset clears the whole edge matrix at once (no edges) and idles the search
//   if the receiver stalls, the result item holds in the output register and
//   no new command is taken until it is read
// ----------------------------------------------------------------------------
module wait_for_graph_deadlock_detector (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  wfg_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output wfg_pkg::out_item_t out_data
);
	import wfg_pkg::*;

	logic               in_acc;
	logic               in_range;
	wfg_wr_t            wr;
	logic [SLOT_W-1:0]  row_addr;
	logic [NUM_TXN-1:0] row;
	logic               srch_busy;
	logic               srch_start;
	logic               res_valid;
	wfg_res_t           res;
	logic               out_valid_q;
	out_item_t          out_q;

	// take a command only when idle and the result slot is free
	assign in_ready = !srch_busy && (!out_valid_q || out_ready);
	assign in_acc   = in_valid && in_ready;

	// slots outside the tracked range leave the matrix alone
	assign in_range = (int'(in_data.waiter) < NUM_TXN) && (int'(in_data.holder) < NUM_TXN);

	always_comb begin
		wr.en  = in_acc && in_range &&
			(in_data.cmd == CMD_ADD || in_data.cmd == CMD_REMOVE);
		wr.set = (in_data.cmd == CMD_ADD);
		wr.row = SLOT_W'(in_data.waiter);
		wr.col = SLOT_W'(in_data.holder);
	end

	assign srch_start = in_acc && (in_data.cmd == CMD_DETECT);

	wfg_edge_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_addr (row_addr),
		.rd_row  (row)
	);

	wfg_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (srch_start),
		.row_addr  (row_addr),
		.row       (row),
		.busy      (srch_busy),
		.res_valid (res_valid),
		.res       (res)
	);

	// output register: edge updates and unused codes answer at once,
	// detect answers when the search posts its result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid || (in_acc && !srch_start)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q.found  <= res.found;
			out_q.victim <= FIELD_W'(res.victim);
		end else if (in_acc && !srch_start) begin
			out_q <= '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: bench/wait_for_graph_deadlock_detector_tb.sv
// ----------------------------------------------------------------------------
// wait_for_graph_deadlock_detector_tb
// Self-checking bench: edge updates and cycle searches against a local graph.
// ----------------------------------------------------------------------------
// a short table of hand-picked commands comes first, then random command
// streams in four idling phases; every result is compared with the table's verdict or one
// computed from a shadow copy of the wait-for graph
// ----------------------------------------------------------------------------
module wait_for_graph_deadlock_detector_tb;
	import wfg_pkg::*;

	// command code that the block must treat as a no-op
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// mark of a slot during the depth-first search
	typedef enum logic [1:0] {
		SLOT_NEW,
		SLOT_ON_PATH,
		SLOT_DONE
	} slot_mark_t;

	localparam int SCRIPT_LEN     = 25;
	localparam int RAND_PER_PHASE = 406;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	// longest search plus a margin, waited out after the last result
	localparam int TAIL_CYCLES    = 3 * NUM_TXN + 16;
	localparam int MAX_REPORTS    = 10;

	// sender idle and receiver stall percentages of the four phases
	localparam int SEND_IDLE [4]  = '{0, 45, 0, 25};
	localparam int RECV_STALL [4] = '{0, 0, 45, 25};

	typedef struct {
		in_item_t  cmd_item;
		bit        typed;
		out_item_t verdict;
	} script_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	// shadow wait-for graph: row w, bit h set means slot w waits on slot h
	logic [NUM_TXN-1:0] graph_rows [NUM_TXN];
	// verdicts owed by the block, oldest first
	out_item_t          due_verdicts [$];
	out_item_t          head_verdict;

	int mismatch_cnt  = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	bit hold_req      = 1'b0;
	int hold_cnt      = 0;
	int quiet_cycles  = 0;

	// hand-picked commands; typed rows carry a verdict that is obvious
	// from the graph at that point, the rest go through the shadow search
	script_row_t script [SCRIPT_LEN] = '{
		// empty graph right after reset
		'{'{CMD_DETECT, 5'd0,  5'd0},  1'b1, '{1'b0, 5'd0}},
		// edge updates always answer with no cycle
		'{'{CMD_ADD,    5'd0,  5'd31}, 1'b1, '{1'b0, 5'd0}},
		'{'{CMD_ADD,    5'd31, 5'd0},  1'b1, '{1'b0, 5'd0}},
		// two-slot cycle across the extreme slots
		'{'{CMD_DETECT, 5'd31, 5'd31}, 1'b1, '{1'b1, 5'd31}},
		'{'{CMD_ADD,    5'd31, 5'd31}, 1'b1, '{1'b0, 5'd0}},
		'{'{CMD_DETECT, 5'd0,  5'd0},  1'b1, '{1'b1, 5'd31}},
		'{'{CMD_REMOVE, 5'd31, 5'd0},  1'b1, '{1'b0, 5'd0}},
		// only the self edge on the top slot is left as a cycle
		'{'{CMD_DETECT, 5'd0,  5'd0},  1'b1, '{1'b1, 5'd31}},
		'{'{CMD_REMOVE, 5'd31, 5'd31}, 1'b1, '{1'b0, 5'd0}},
		'{'{CMD_REMOVE, 5'd0,  5'd31}, 1'b1, '{1'b0, 5'd0}},
		// unused code must not touch the graph
		'{'{CMD_UNUSED, 5'd31, 5'd31}, 1'b1, '{1'b0, 5'd0}},
		'{'{CMD_DETECT, 5'd0,  5'd0},  1'b1, '{1'b0, 5'd0}},
		// self edge in the middle of the slot range
		'{'{CMD_ADD,    5'd5,  5'd5},  1'b1, '{1'b0, 5'd0}},
		'{'{CMD_DETECT, 5'd0,  5'd0},  1'b1, '{1'b1, 5'd5}},
		'{'{CMD_REMOVE, 5'd5,  5'd5},  1'b1, '{1'b0, 5'd0}},
		// three-slot ring, then a detour through a high slot
		'{'{CMD_ADD,    5'd1,  5'd2},  1'b0, '{1'b0, 5'd0}},
		'{'{CMD_ADD,    5'd2,  5'd3},  1'b0, '{1'b0, 5'd0}},
		'{'{CMD_ADD,    5'd3,  5'd1},  1'b0, '{1'b0, 5'd0}},
		'{'{CMD_DETECT, 5'd0,  5'd0},  1'b0, '{1'b0, 5'd0}},
		'{'{CMD_REMOVE, 5'd3,  5'd1},  1'b0, '{1'b0, 5'd0}},
		'{'{CMD_ADD,    5'd3,  5'd30}, 1'b0, '{1'b0, 5'd0}},
		'{'{CMD_ADD,    5'd30, 5'd2},  1'b0, '{1'b0, 5'd0}},
		'{'{CMD_DETECT, 5'd0,  5'd0},  1'b0, '{1'b0, 5'd0}},
		// removing an edge that is not there is still answered
		'{'{CMD_REMOVE, 5'd1,  5'd31}, 1'b1, '{1'b0, 5'd0}},
		'{'{CMD_DETECT, 5'd31, 5'd0},  1'b0, '{1'b0, 5'd0}}
	};

	wait_for_graph_deadlock_detector u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #1 clk = ~clk;

	// depth-first search over the shadow graph: ascending roots, ascending
	// neighbours, stop at the first edge back onto the current path
	function automatic out_item_t first_deadlock();
		slot_mark_t mark [NUM_TXN];
		int         next_nb [NUM_TXN];
		int         path [NUM_TXN];
		int         depth;
		int         v;
		int         j;
		int         best;
		bit         advanced;
		out_item_t  res;
		res = '0;
		for (int k = 0; k < NUM_TXN; k++) begin
			mark[k]    = SLOT_NEW;
			next_nb[k] = 0;
		end
		for (int root = 0; root < NUM_TXN; root++) begin
			if (mark[root] != SLOT_NEW)
				continue;
			mark[root] = SLOT_ON_PATH;
			path[0]    = root;
			depth      = 1;
			while (depth > 0) begin
				v        = path[depth-1];
				advanced = 1'b0;
				for (j = next_nb[v]; j < NUM_TXN && !advanced; j++) begin
					if (graph_rows[v][j]) begin
						next_nb[v] = j + 1;
						if (mark[j] == SLOT_ON_PATH) begin
							// walk back from the top of the path to the slot hit
							best = 0;
							for (int i = depth - 1; i >= 0; i--) begin
								if (path[i] > best)
									best = path[i];
								if (path[i] == j)
									break;
							end
							res.found  = 1'b1;
							res.victim = best[FIELD_W-1:0];
							return res;
						end
						if (mark[j] == SLOT_NEW) begin
							mark[j]     = SLOT_ON_PATH;
							path[depth] = j;
							depth++;
							advanced = 1'b1;
						end
					end
				end
				if (!advanced) begin
					next_nb[v] = NUM_TXN;
					mark[v]    = SLOT_DONE;
					depth--;
				end
			end
		end
		return res;
	endfunction

	// apply one command to the shadow graph and return the verdict it earns
	function automatic out_item_t exec_graph_cmd(input in_item_t it);
		out_item_t res;
		res = '0;
		case (it.cmd)
			CMD_ADD: begin
				if (it.waiter < NUM_TXN && it.holder < NUM_TXN)
					graph_rows[it.waiter][it.holder] = 1'b1;
			end
			CMD_REMOVE: begin
				if (it.waiter < NUM_TXN && it.holder < NUM_TXN)
					graph_rows[it.waiter][it.holder] = 1'b0;
			end
			CMD_DETECT: begin
				res = first_deadlock();
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// random command shaped by the current graph: mostly short forward hops
	// that build long chains, a few random edges that close cycles, and
	// removals of live edges to keep the density moderate
	function automatic in_item_t random_cmd();
		in_item_t it;
		int       pick;
		int       edge_total;
		int       add_pct;
		int       hop;
		int       r;
		int       c;
		edge_total = 0;
		for (int k = 0; k < NUM_TXN; k++)
			edge_total += $countones(graph_rows[k]);
		add_pct   = (edge_total > 40) ? 25 : 50;
		it.waiter = FIELD_W'($urandom_range(NUM_TXN - 1));
		it.holder = FIELD_W'($urandom_range(NUM_TXN - 1));
		pick      = $urandom_range(99);
		if (pick < 2) begin
			it.cmd = CMD_UNUSED;
		end else if (pick < 18) begin
			it.cmd = CMD_DETECT;
		end else if (pick < 18 + add_pct) begin
			it.cmd = CMD_ADD;
			if ($urandom_range(9) < 8 && it.waiter < NUM_TXN - 1) begin
				hop = NUM_TXN - 2 - it.waiter;
				if (hop > 2)
					hop = 2;
				c         = it.waiter + 1 + $urandom_range(hop);
				it.holder = c[FIELD_W-1:0];
			end
		end else begin
			it.cmd = CMD_REMOVE;
			if (edge_total > 0 && $urandom_range(9) < 8) begin
				do
					r = $urandom_range(NUM_TXN - 1);
				while (graph_rows[r] == '0);
				do
					c = $urandom_range(NUM_TXN - 1);
				while (!graph_rows[r][c]);
				it.waiter = r[FIELD_W-1:0];
				it.holder = c[FIELD_W-1:0];
			end
		end
		return it;
	endfunction

	// offer one item, idling first at the current rate; the verdict is
	// worked out once the block takes the item
	task automatic offer_cmd(input in_item_t it, input bit typed, input out_item_t typed_verdict);
		out_item_t v;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		v = exec_graph_cmd(it);
		due_verdicts.insert(due_verdicts.size(), typed ? typed_verdict : v);
	endtask

	// stimulus
	initial begin
		for (int k = 0; k < NUM_TXN; k++)
			graph_rows[k] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int n = 0; n < SCRIPT_LEN; n++)
			offer_cmd(script[n].cmd_item, script[n].typed, script[n].verdict);

		// random streams, one idling pattern per phase
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = SEND_IDLE[ph];
			stall_pct    <= RECV_STALL[ph];
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				// long receiver hold-off while items keep coming
				if (ph == 0 && n == 150)
					hold_req <= 1'b1;
				offer_cmd(random_cmd(), 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		// drain, then give a late or spurious result time to show up
		while (due_verdicts.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatch_cnt == 0 && due_verdicts.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// receiver: check each taken result, then pick next cycle's ready
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_verdicts.size() == 0) begin
					if (mismatch_cnt < MAX_REPORTS)
						$display("result with nothing due: found %0b victim %0d",
							out_data.found, out_data.victim);
					mismatch_cnt++;
				end else begin
					head_verdict = due_verdicts.pop_front();
					if (out_data.found !== head_verdict.found ||
						out_data.victim !== head_verdict.victim) begin
						if (mismatch_cnt < MAX_REPORTS)
							$display("mismatch: found exp %0b got %0b, victim exp %0d got %0d",
								head_verdict.found, out_data.found,
								head_verdict.victim, out_data.victim);
						mismatch_cnt++;
					end
				end
			end
			// the hold-off runs once, counted here, then random stalls resume
			if (hold_req && hold_cnt < HOLD_CYCLES) begin
				hold_cnt  <= hold_cnt + 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// watchdog: too long without any item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

endmodule
